// ===== rtl/core/lru_cache_with_next_line_prefetch_top_assert.svh =====
// assertion macros for the cache block
`ifndef LRU_CACHE_WITH_NEXT_LINE_PREFETCH_TOP_ASSERT_SVH
`define LRU_CACHE_WITH_NEXT_LINE_PREFETCH_TOP_ASSERT_SVH
`define LCP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/lcp_pkg.sv =====
// shared types and constants for the cache block
`timescale 1ns / 1ps
package lcp_pkg;
  localparam int WAYS_DEF = 8;
  localparam int SETS_DEF = 256;
  localparam int ADDR_BITS_DEF = 48;
  localparam int MAX_OFFSET = 12;
  localparam int MAX_INDEX = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREFETCH = 2'd3;
  localparam logic MODE_READ = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [3:0] index_bits;
    logic [3:0] ways_in_use;
    logic       prefetch_enable;
  } cfg_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] memory_reads;
    logic       memory_write;
    logic       prefetch_fill;
    logic [31:0] total_reads;
    logic [31:0] total_writes;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
  } result_t;

  typedef struct packed {
    logic mode;
    logic [47:0] address;
  } request_t;
endpackage

// ===== rtl/core/lcp_stream_if.sv =====
// valid/ready channel interface
`timescale 1ns / 1ps
interface lcp_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lcp_ram.sv =====
// generic ram with one write port and a separate registered read port
`timescale 1ns / 1ps
module lcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/lcp_front.sv =====
// request intake and queue toward the set engine
`timescale 1ns / 1ps
module lcp_front (
  input  logic clk,
  input  logic rst_n,
  lcp_stream_if.sink   req_in,
  lcp_stream_if.source req_out
);
  lcp_pkg::request_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign req_in.ready = (cnt_r != 2'd2);
  assign req_out.valid = (cnt_r != 2'd0);
  assign req_out.data = q_r[rp_r];
  assign push = req_in.valid && req_in.ready;
  assign pop = req_out.valid && req_out.ready;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= req_in.data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/core/lcp_back.sv =====
// set lookup, lru update, prefetch and counters
`timescale 1ns / 1ps
`include "lru_cache_with_next_line_prefetch_top_assert.svh"
module lcp_back #(
  parameter int WAYS = lcp_pkg::WAYS_DEF,
  parameter int SETS = lcp_pkg::SETS_DEF,
  parameter int ADDR_BITS = lcp_pkg::ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  lcp_pkg::cfg_t cfg,
  lcp_stream_if.sink   req,
  lcp_stream_if.source res
);
  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(WAYS + 1);
  localparam int ROW_W = WAYS * (ADDR_BITS + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001, ST_DRD = 6'b000010, ST_DUPD = 6'b000100,
    ST_PRD = 6'b001000, ST_PUPD = 6'b010000, ST_CLR = 6'b100000
  } st_t;

  st_t st_r;
  logic [SW-1:0] clr_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic mode_r, hit_r, pf_r;
  logic out_v_r;
  lcp_pkg::result_t out_r;
  logic [31:0] rd_cnt_r, wr_cnt_r, hit_cnt_r, miss_cnt_r;

  logic [3:0] off_e, idx_e;
  logic [CW-1:0] ways_e;
  logic [ADDR_BITS-1:0] cur_addr, next_addr, tag;
  logic [SW-1:0] set_idx;
  logic [ROW_W-1:0] row_rd, row_wr;
  logic ram_we;
  logic clr_act;
  logic ram_wen;
  logic [SW-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ADDR_BITS-1:0] tags [WAYS];
  logic [WAYS-1:0] vrow, vnew;
  logic [ADDR_BITS-1:0] tnew [WAYS];
  logic found;
  logic [WW-1:0] hidx, eidx;
  logic efound;
  logic touch;

  always_comb begin
    off_e = (cfg.offset_bits > 4'(lcp_pkg::MAX_OFFSET)) ? 4'(lcp_pkg::MAX_OFFSET)
                                                         : cfg.offset_bits;
    idx_e = (cfg.index_bits > 4'(lcp_pkg::MAX_INDEX)) ? 4'(lcp_pkg::MAX_INDEX)
                                                       : cfg.index_bits;
    for (int k = 0; k < lcp_pkg::MAX_INDEX; k++)
      if (idx_e > 4'd0 && (32'd1 << idx_e) > 32'(SETS)) idx_e = idx_e - 4'd1;
    if (cfg.ways_in_use == 4'd0) ways_e = CW'(1);
    else if (32'(cfg.ways_in_use) > 32'(WAYS)) ways_e = CW'(WAYS);
    else ways_e = CW'(cfg.ways_in_use);
  end

  assign next_addr = addr_r + (ADDR_BITS'(1) << off_e);
  assign cur_addr = (st_r == ST_PRD || st_r == ST_PUPD) ? next_addr : addr_r;
  assign tag = (cur_addr >> off_e) >> idx_e;
  assign set_idx = SW'((cur_addr >> off_e) & ((ADDR_BITS'(1) << idx_e) - 1'b1));
  assign touch = (st_r == ST_DUPD);

  // clearing pass after reset empties every set
  assign clr_act = (st_r == ST_CLR);
  assign ram_wen = ram_we || clr_act;
  assign ram_waddr = clr_act ? clr_r : set_idx;
  assign ram_wdata = clr_act ? '0 : row_wr;

  lcp_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_tags (
    .clk(clk), .we(ram_wen), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(set_idx), .rdata(row_rd)
  );

  always_comb begin
    found = 1'b0;
    hidx = '0;
    efound = 1'b0;
    eidx = WW'(ways_e - 1'b1);
    for (int i = 0; i < WAYS; i++) begin
      tags[i] = row_rd[i*(ADDR_BITS+1) +: ADDR_BITS];
      vrow[i] = row_rd[i*(ADDR_BITS+1) + ADDR_BITS];
    end
    for (int i = 0; i < WAYS; i++) begin
      if (!found && CW'(i) < ways_e && vrow[i] && tags[i] == tag) begin
        found = 1'b1;
        hidx = WW'(i);
      end
      if (!efound && CW'(i) < ways_e && !vrow[i]) begin
        efound = 1'b1;
        eidx = WW'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      tnew[i] = tags[i];
      vnew[i] = vrow[i];
    end
    if (found) begin
      if (touch) begin
        for (int i = 1; i < WAYS; i++) if (WW'(i) <= hidx) tnew[i] = tags[i-1];
        tnew[0] = tag;
      end
    end else begin
      for (int i = 1; i < WAYS; i++)
        if (WW'(i) <= eidx) begin
          tnew[i] = tags[i-1];
          vnew[i] = vrow[i-1];
        end
      tnew[0] = tag;
      vnew[0] = 1'b1;
    end
    row_wr = '0;
    for (int i = 0; i < WAYS; i++) begin
      row_wr[i*(ADDR_BITS+1) +: ADDR_BITS] = tnew[i];
      row_wr[i*(ADDR_BITS+1) + ADDR_BITS] = vnew[i];
    end
    ram_we = (st_r == ST_DUPD || st_r == ST_PUPD) && (!found || touch);
  end

  assign req.ready = (st_r == ST_IDLE) && !out_v_r;
  assign res.valid = out_v_r;
  assign res.data = out_r;

  function automatic logic [31:0] sat_add(input logic [31:0] c, input logic [1:0] n);
    logic [32:0] s;
    s = {1'b0, c} + 33'(n);
    return s[32] ? lcp_pkg::CNT_MAX : s[31:0];
  endfunction

  logic finish;
  assign finish = (st_r == ST_DUPD && (found || !cfg.prefetch_enable)) || st_r == ST_PUPD;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      addr_r <= ADDR_BITS'(req.data.address);
      mode_r <= req.data.mode;
    end
    if (st_r == ST_DUPD) begin
      hit_r <= found;
      pf_r <= 1'b0;
    end
    if (st_r == ST_PUPD) pf_r <= !found;
    if (!rst_n) begin
      st_r <= ST_CLR;
      clr_r <= '0;
      out_v_r <= 1'b0;
      rd_cnt_r <= '0;
      wr_cnt_r <= '0;
      hit_cnt_r <= '0;
      miss_cnt_r <= '0;
    end else begin
      if (res.valid && res.ready) out_v_r <= 1'b0;
      case (st_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SW'(SETS - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: if (req.valid && req.ready) st_r <= ST_DRD;
        ST_DRD: st_r <= ST_DUPD;
        ST_DUPD: begin
          if (found) hit_cnt_r <= sat_add(hit_cnt_r, 2'd1);
          else miss_cnt_r <= sat_add(miss_cnt_r, 2'd1);
          st_r <= (!found && cfg.prefetch_enable) ? ST_PRD : ST_IDLE;
        end
        ST_PRD: st_r <= ST_PUPD;
        ST_PUPD: st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
      if (finish) begin
        logic h, p;
        logic [1:0] n;
        logic [31:0] rc, wc;
        h = (st_r == ST_DUPD) ? found : hit_r;
        p = (st_r == ST_PUPD) && !found;
        n = h ? 2'd0 : (p ? 2'd2 : 2'd1);
        rc = sat_add(rd_cnt_r, n);
        wc = mode_r ? sat_add(wr_cnt_r, 2'd1) : wr_cnt_r;
        rd_cnt_r <= rc;
        wr_cnt_r <= wc;
        out_v_r <= 1'b1;
        out_r.hit <= h;
        out_r.memory_reads <= n;
        out_r.memory_write <= (mode_r == lcp_pkg::MODE_WRITE);
        out_r.prefetch_fill <= p;
        out_r.total_reads <= rc;
        out_r.total_writes <= wc;
        out_r.total_hits <= (st_r == ST_DUPD && found) ? sat_add(hit_cnt_r, 2'd1)
                                                        : hit_cnt_r;
        out_r.total_misses <= (st_r == ST_DUPD && !found) ? sat_add(miss_cnt_r, 2'd1)
                                                           : miss_cnt_r;
      end
    end
  end

  `LCP_ASSERT_IMPL(a_ready_idle, clk, rst_n, req.ready, st_r == ST_IDLE)
  `LCP_ASSERT_IMPL(a_onehot, clk, rst_n, 1'b1, $onehot(st_r))
  `LCP_ASSERT_NEXT(a_fin_valid, clk, rst_n, finish, res.valid)
  `LCP_ASSERT_IMPL(a_no_wr_idle, clk, rst_n, st_r == ST_IDLE, !ram_we)
  `LCP_ASSERT_IMPL(a_clr_no_req, clk, rst_n, st_r == ST_CLR, !req.ready)
endmodule

// ===== rtl/core/lru_cache_with_next_line_prefetch_top.sv =====
// top level of the lru cache with next-line prefetch
// channel | dir | payload
// in_     | in  | mode, address
// out_    | out | hit, memory_reads, memory_write, prefetch_fill, four totals
// cfg_    | in  | register index, write data
// a request goes through a read state and an update state for its own set; on a miss
// with prefetch on, a second read state and update state follow for the next line
// reset is synchronous; counters and config return to reset values
// after reset the tag ram is cleared one set per cycle, all SETS sets (256 by default)
// a result waiting at the output holds off the next request in the back part
`timescale 1ns / 1ps
module lru_cache_with_next_line_prefetch_top #(
  parameter int WAYS = lcp_pkg::WAYS_DEF,
  parameter int SETS = lcp_pkg::SETS_DEF,
  parameter int ADDR_BITS = lcp_pkg::ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lcp_stream_if.sink   in_req,
  lcp_stream_if.source out_res,
  input  logic cfg_we,
  input  logic [lcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcp_pkg::CFG_DATA_W-1:0] cfg_data
);
  lcp_pkg::cfg_t cfg_r;
  lcp_stream_if #(.T(lcp_pkg::request_t)) q_if ();

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_bits <= 4'd6;
      cfg_r.index_bits <= 4'd0;
      cfg_r.ways_in_use <= 4'd1;
      cfg_r.prefetch_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lcp_pkg::REG_OFFSET: cfg_r.offset_bits <= cfg_data;
        lcp_pkg::REG_INDEX: cfg_r.index_bits <= cfg_data;
        lcp_pkg::REG_WAYS: cfg_r.ways_in_use <= cfg_data;
        lcp_pkg::REG_PREFETCH: cfg_r.prefetch_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lcp_front u_front (.clk(clk), .rst_n(rst_n), .req_in(in_req), .req_out(q_if));

  lcp_back #(.WAYS(WAYS), .SETS(SETS), .ADDR_BITS(ADDR_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .req(q_if), .res(out_res)
  );
endmodule

// ===== test/tb_lru_cache_with_next_line_prefetch_top.sv =====
// self-checking testbench for the lru cache with next-line prefetch
`timescale 1ns / 1ps
module tb_lru_cache_with_next_line_prefetch_top;
  localparam int NWAYS = 8;
  localparam int NSETS = 256;
  localparam int RAND_PER_PHASE = 275;

  typedef struct {
    logic        mode;
    logic [47:0] address;
    bit          typed;
    logic        hit;
    logic [1:0]  memory_reads;
    logic        memory_write;
    logic        prefetch_fill;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [lcp_pkg::CFG_IDX_W-1:0] cfg_index = lcp_pkg::REG_OFFSET;
  logic [lcp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  lcp_stream_if #(.T(lcp_pkg::request_t)) in_req ();
  lcp_stream_if #(.T(lcp_pkg::result_t)) out_res ();

  lru_cache_with_next_line_prefetch_top dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [47:0] tags [NSETS][NWAYS];
  bit          valids [NSETS][NWAYS];
  logic [31:0] cnt_reads, cnt_writes, cnt_hits, cnt_misses;
  lcp_pkg::cfg_t cur_cfg;

  lcp_pkg::result_t pending_results [$];
  int errors = 0;
  int n_items = 0;
  int n_hits = 0;
  int n_prefetch = 0;
  bit hold_long = 1'b0;
  bit sender_busy_phase = 1'b1;
  bit typed_pending [$];
  dir_row_t typed_rows [$];

  function automatic logic [31:0] sat_inc(logic [31:0] c, int n);
    return (c > lcp_pkg::CNT_MAX - 32'(n)) ? lcp_pkg::CNT_MAX : c + 32'(n);
  endfunction

  function automatic int eff_off();
    return (cur_cfg.offset_bits > lcp_pkg::MAX_OFFSET) ? lcp_pkg::MAX_OFFSET
                                                       : int'(cur_cfg.offset_bits);
  endfunction

  function automatic int eff_idx();
    return (cur_cfg.index_bits > lcp_pkg::MAX_INDEX) ? lcp_pkg::MAX_INDEX
                                                     : int'(cur_cfg.index_bits);
  endfunction

  function automatic int eff_ways();
    if (cur_cfg.ways_in_use == 0) return 1;
    return (cur_cfg.ways_in_use > NWAYS) ? NWAYS : int'(cur_cfg.ways_in_use);
  endfunction

  function automatic bit lookup_block(logic [47:0] a, bit touch);
    int off, ib, w, s, e;
    logic [63:0] tg;
    off = eff_off();
    ib = eff_idx();
    w = eff_ways();
    s = int'((64'(a) >> off) & ((64'd1 << ib) - 1));
    tg = 64'(a) >> (off + ib);
    for (int i = 0; i < w; i++) begin
      if (valids[s][i] && tags[s][i] == tg[47:0]) begin
        if (touch) begin
          for (int k = i; k > 0; k--) tags[s][k] = tags[s][k-1];
          tags[s][0] = tg[47:0];
        end
        return 1'b1;
      end
    end
    e = w - 1;
    for (int i = 0; i < w; i++) begin
      if (!valids[s][i]) begin
        e = i;
        break;
      end
    end
    for (int i = e; i > 0; i--) begin
      tags[s][i] = tags[s][i-1];
      valids[s][i] = valids[s][i-1];
    end
    tags[s][0] = tg[47:0];
    valids[s][0] = 1'b1;
    return 1'b0;
  endfunction

  function automatic lcp_pkg::result_t predict_access(lcp_pkg::request_t rq);
    lcp_pkg::result_t r;
    logic [47:0] nxt;
    r = '0;
    r.hit = lookup_block(rq.address, 1'b1);
    if (r.hit) begin
      cnt_hits = sat_inc(cnt_hits, 1);
    end else begin
      cnt_misses = sat_inc(cnt_misses, 1);
      r.memory_reads = 2'd1;
      if (cur_cfg.prefetch_enable) begin
        nxt = rq.address + (48'd1 << eff_off());
        if (!lookup_block(nxt, 1'b0)) begin
          r.prefetch_fill = 1'b1;
          r.memory_reads = 2'd2;
        end
      end
    end
    cnt_reads = sat_inc(cnt_reads, int'(r.memory_reads));
    if (rq.mode == lcp_pkg::MODE_WRITE) cnt_writes = sat_inc(cnt_writes, 1);
    r.memory_write = (rq.mode == lcp_pkg::MODE_WRITE);
    r.total_reads = cnt_reads;
    r.total_writes = cnt_writes;
    r.total_hits = cnt_hits;
    r.total_misses = cnt_misses;
    return r;
  endfunction

  task automatic report(string fld, logic [31:0] got, logic [31:0] exp_v);
    if (got !== exp_v) begin
      errors++;
      $display("mismatch on %s: got %0h, expected %0h", fld, got, exp_v);
    end
  endtask

  // scoreboard: check results, then predict newly accepted requests
  always @(posedge clk) begin
    lcp_pkg::result_t e, g;
    if (rst_n && out_res.valid && out_res.ready) begin
      g = out_res.data;
      if (pending_results.size() == 0) begin
        report("result with no request outstanding", 32'd1, 32'd0);
      end else begin
        e = pending_results.pop_front();
        report("hit", 32'(g.hit), 32'(e.hit));
        report("memory_reads", 32'(g.memory_reads), 32'(e.memory_reads));
        report("memory_write", 32'(g.memory_write), 32'(e.memory_write));
        report("prefetch_fill", 32'(g.prefetch_fill), 32'(e.prefetch_fill));
        report("total_reads", g.total_reads, e.total_reads);
        report("total_writes", g.total_writes, e.total_writes);
        report("total_hits", g.total_hits, e.total_hits);
        report("total_misses", g.total_misses, e.total_misses);
        n_hits += int'(g.hit);
        n_prefetch += int'(g.prefetch_fill);
      end
    end
    if (rst_n && in_req.valid && in_req.ready) begin
      e = predict_access(in_req.data);
      if (typed_pending.pop_front()) begin
        dir_row_t t;
        t = typed_rows.pop_front();
        // hand-computed flags must agree with the predictor too
        report("typed hit", 32'(e.hit), 32'(t.hit));
        report("typed memory_reads", 32'(e.memory_reads), 32'(t.memory_reads));
        report("typed memory_write", 32'(e.memory_write), 32'(t.memory_write));
        report("typed prefetch_fill", 32'(e.prefetch_fill), 32'(t.prefetch_fill));
        e.hit = t.hit;
        e.memory_reads = t.memory_reads;
        e.memory_write = t.memory_write;
        e.prefetch_fill = t.prefetch_fill;
      end
      pending_results.push_back(e);
      n_items++;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int d;
    out_res.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        d = 300;
        hold_long = 1'b0;
      end else begin
        d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (d > 0) begin
        out_res.ready <= 1'b0;
        repeat (d) @(negedge clk);
      end
      out_res.ready <= 1'b1;
      do @(posedge clk); while (!(out_res.valid && out_res.ready));
    end
  end

  task automatic send_request(logic mode, logic [47:0] addr);
    int gap;
    gap = sender_busy_phase ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data <= '{mode: mode, address: addr};
    do @(posedge clk); while (!in_req.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_cfg(logic [lcp_pkg::CFG_IDX_W-1:0] idx,
                           logic [lcp_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lcp_pkg::REG_OFFSET: cur_cfg.offset_bits = val;
      lcp_pkg::REG_INDEX: cur_cfg.index_bits = val;
      lcp_pkg::REG_WAYS: cur_cfg.ways_in_use = val;
      lcp_pkg::REG_PREFETCH: cur_cfg.prefetch_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(lcp_pkg::cfg_t c);
    write_cfg(lcp_pkg::REG_OFFSET, c.offset_bits);
    write_cfg(lcp_pkg::REG_INDEX, c.index_bits);
    write_cfg(lcp_pkg::REG_WAYS, c.ways_in_use);
    write_cfg(lcp_pkg::REG_PREFETCH, {3'b0, c.prefetch_enable});
  endtask

  task automatic push_row(dir_row_t r);
    if (r.typed) typed_rows.push_back(r);
    typed_pending.push_back(r.typed);
    send_request(r.mode, r.address);
  endtask

  dir_row_t reset_rows [5];
  dir_row_t pf_rows [12];
  lcp_pkg::cfg_t rand_cfgs [8];

  initial begin
    logic [47:0] base, a;
    int eo, blocks;
    in_req.valid = 1'b0;
    in_req.data = '0;
    for (int s = 0; s < NSETS; s++)
      for (int w = 0; w < NWAYS; w++) begin
        tags[s][w] = '0;
        valids[s][w] = 1'b0;
      end
    cnt_reads = 0; cnt_writes = 0; cnt_hits = 0; cnt_misses = 0;
    cur_cfg = '{offset_bits: 4'd6, index_bits: 4'd0, ways_in_use: 4'd1,
                prefetch_enable: 1'b0};

    // reset values: 64-byte blocks, one set, one way, no prefetch
    reset_rows[0] = '{lcp_pkg::MODE_READ,  48'h0,             1, 0, 2'd1, 0, 0};
    reset_rows[1] = '{lcp_pkg::MODE_READ,  48'h0,             1, 1, 2'd0, 0, 0};
    reset_rows[2] = '{lcp_pkg::MODE_WRITE, 48'hFFFF_FFFF_FFFF, 1, 0, 2'd1, 1, 0};
    reset_rows[3] = '{lcp_pkg::MODE_READ,  48'h0,             1, 0, 2'd1, 0, 0};
    reset_rows[4] = '{lcp_pkg::MODE_WRITE, 48'h3F,            1, 1, 2'd0, 1, 0};
    // prefetch on: wrap past the top, prefetch hit, out of range registers
    pf_rows[0]  = '{lcp_pkg::MODE_READ,  48'hFFFF_FFFF_FFC0, 0, 0, 0, 0, 0};
    pf_rows[1]  = '{lcp_pkg::MODE_READ,  48'h40,             0, 0, 0, 0, 0};
    pf_rows[2]  = '{lcp_pkg::MODE_READ,  48'h80,             0, 0, 0, 0, 0};
    pf_rows[3]  = '{lcp_pkg::MODE_WRITE, 48'hC0,             0, 0, 0, 0, 0};
    pf_rows[4]  = '{lcp_pkg::MODE_READ,  48'h40,             0, 0, 0, 0, 0};
    pf_rows[5]  = '{lcp_pkg::MODE_WRITE, 48'h1000,           0, 0, 0, 0, 0};
    pf_rows[6]  = '{lcp_pkg::MODE_READ,  48'hAAAA_AAAA_AAAA, 0, 0, 0, 0, 0};
    pf_rows[7]  = '{lcp_pkg::MODE_WRITE, 48'h5555_5555_5555, 0, 0, 0, 0, 0};
    pf_rows[8]  = '{lcp_pkg::MODE_READ,  48'h80,             0, 0, 0, 0, 0};
    pf_rows[9]  = '{lcp_pkg::MODE_READ,  48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0};
    pf_rows[10] = '{lcp_pkg::MODE_WRITE, 48'h0,              0, 0, 0, 0, 0};
    pf_rows[11] = '{lcp_pkg::MODE_READ,  48'h1040,           0, 0, 0, 0, 0};

    rand_cfgs[0] = '{4'd0,  4'd0,  4'd1,  1'b1};
    rand_cfgs[1] = '{4'd12, 4'd8,  4'd8,  1'b1};
    rand_cfgs[2] = '{4'd15, 4'd15, 4'd0,  1'b1};
    rand_cfgs[3] = '{4'd4,  4'd3,  4'd3,  1'b0};
    rand_cfgs[4] = '{4'd2,  4'd2,  4'd8,  1'b1};
    rand_cfgs[5] = '{4'd0,  4'd8,  4'd15, 1'b0};
    rand_cfgs[6] = '{4'd6,  4'd4,  4'd4,  1'b1};
    rand_cfgs[7] = '{4'd3,  4'd1,  4'd2,  1'b1};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    apply_cfg(cur_cfg);

    foreach (reset_rows[i]) push_row(reset_rows[i]);
    wait_idle();
    apply_cfg('{4'd6, 4'd0, 4'd2, 1'b1});
    foreach (pf_rows[i]) push_row(pf_rows[i]);
    wait_idle();
    apply_cfg('{4'd13, 4'd9, 4'd9, 1'b1});
    foreach (pf_rows[i]) if (i < 4) push_row(pf_rows[i]);
    wait_idle();

    foreach (rand_cfgs[p]) begin
      apply_cfg(rand_cfgs[p]);
      sender_busy_phase = (p % 3 == 1);
      if (p == 2) hold_long = 1'b1;
      base = 48'({$urandom, $urandom});
      eo = eff_off();
      blocks = (1 << eff_idx()) * 4;
      for (int n = 0; n < RAND_PER_PHASE - 35; n++) begin
        if ($urandom_range(0, 9) < 8) begin
          a = base + (48'($urandom_range(0, blocks - 1)) << eo)
              + 48'($urandom & ((1 << eo) - 1));
        end else begin
          a = 48'({$urandom, $urandom});
        end
        typed_pending.push_back(1'b0);
        send_request(1'($urandom_range(0, 1)), a);
      end
      wait_idle();
    end

    $display("covered %0d requests over %0d register settings with random stalls",
             n_items, 11);
    $display("saw %0d hits and %0d prefetch fills", n_hits, n_prefetch);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end
endmodule
